>>> rtl/scalar_label_colormap_rgba_unit_assert.svh
// Assertion macros for the colormap unit
`ifndef SCALAR_LABEL_COLORMAP_RGBA_UNIT_ASSERT_SVH
`define SCALAR_LABEL_COLORMAP_RGBA_UNIT_ASSERT_SVH

// pre holds at an edge -> post holds at the same edge
`define SLCM_ASSERT_IMP(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("slcm assertion failed");

// pre holds at an edge -> post holds at the next edge
`define SLCM_ASSERT_NXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("slcm assertion failed");

`endif

>>> rtl/slcm_pkg.sv
// Shared types, constants and colour stop table of the colormap unit
`timescale 1ns / 1ps
`default_nettype none
package slcm_pkg;
  localparam int MAP_COUNT     = 5;
  localparam int STOP_COUNT    = 7;
  localparam int SEG_COUNT     = STOP_COUNT - 1;
  localparam int SEG_W         = $clog2(STOP_COUNT);
  localparam int STOP_BITS     = 16;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 3;
  localparam logic [31:0] GOLDEN_Q32 = 32'd2654435775;

  localparam logic [CFG_IDX_W-1:0] REG_COLORMAP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KIND     = 1'b1;

  localparam logic [STOP_BITS:0] STOP_TABLE [MAP_COUNT][STOP_COUNT][3] = '{
    '{'{17'd0, 17'd0, 17'd0}, '{17'd10945, 17'd10945, 17'd10945},
      '{17'd21823, 17'd21823, 17'd21823}, '{17'd32768, 17'd32768, 17'd32768},
      '{17'd43713, 17'd43713, 17'd43713}, '{17'd54591, 17'd54591, 17'd54591},
      '{17'd65536, 17'd65536, 17'd65536}},
    '{'{17'd17498, 17'd328, 17'd21561}, '{17'd18547, 17'd9241, 17'd30015},
      '{17'd16646, 17'd17367, 17'd34734}, '{17'd10748, 17'd30867, 17'd36569},
      '{17'd8847, 17'd43188, 17'd33948}, '{17'd31326, 17'd53805, 17'd20840},
      '{17'd65077, 17'd59376, 17'd9437}},
    '{'{17'd66, 17'd0, 17'd918}, '{17'd12124, 17'd4456, 17'd24379},
      '{17'd29557, 17'd7995, 17'd33161}, '{17'd46924, 17'd14090, 17'd31130},
      '{17'd61145, 17'd26870, 17'd23134}, '{17'd65077, 17'd44630, 17'd24969},
      '{17'd64684, 17'd64946, 17'd49152}},
    '{'{17'd12452, 17'd4719, 17'd15204}, '{17'd14615, 17'd37814, 17'd59113},
      '{17'd12845, 17'd58982, 17'd40370}, '{17'd47186, 17'd64225, 17'd14549},
      '{17'd64750, 17'd46989, 17'd7537}, '{17'd59834, 17'd20251, 17'd2818},
      '{17'd31392, 17'd786, 17'd721}},
    '{'{17'd0, 17'd0, 17'd0}, '{17'd26214, 17'd0, 17'd0}, '{17'd52429, 17'd0, 17'd0},
      '{17'd65536, 17'd13107, 17'd0}, '{17'd65536, 17'd39322, 17'd0},
      '{17'd65536, 17'd62259, 17'd13107}, '{17'd65536, 17'd65536, 17'd65536}}
  };

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_DIV, S_SEL, S_MIX, S_BYTE,
    S_LHUE, S_LSECT, S_LRGB, S_DONE
  } state_t;

  typedef struct packed {
    logic       capture;
    logic       fold;
    logic       prep;
    logic       div_step;
    logic       sel;
    logic       mix;
    logic       byte_w;
    logic       lhue;
    logic       lsect;
    logic       lrgb;
    logic       out_load;
    logic [1:0] ch;
  } cmd_t;

  typedef struct packed {
    logic kind;
    logic out_busy;
  } status_t;
endpackage
`default_nettype wire

>>> rtl/slcm_dp.sv
// Datapath: range fold, config, divider, interpolation, label hue, output register
`timescale 1ns / 1ps
`default_nettype none
module slcm_dp #(
  parameter int FRACTION_BITS = slcm_pkg::FRACTION_BITS_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire slcm_pkg::cmd_t             cmd,
  output slcm_pkg::status_t               st,
  input  wire                             in_tuser,
  input  wire  [31:0]                     in_tdata,
  input  wire                             in_tlast,
  input  wire                             cfg_we,
  input  wire  [slcm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [slcm_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                            out_tvalid,
  input  wire                             out_tready,
  output logic [95:0]                     out_tdata,
  output logic                            out_tlast
);
  import slcm_pkg::*;

  localparam int F   = FRACTION_BITS;
  localparam int PW  = 32 + SEG_W;
  localparam int NB  = PW + F;
  localparam int QW  = SEG_W + F;
  localparam int MW  = STOP_BITS + 1 + F;
  localparam int PMW = F + 20;
  localparam logic [QW-1:0] FULL_POS = QW'(SEG_COUNT) << F;

  logic [2:0]         cmap_r;
  logic               kind_r;
  logic signed [31:0] low_r, high_r;
  logic               pass_start_r;
  logic [31:0]        value_r;
  logic               mode_r, last_r;
  logic [31:0]        span_r, rem_r;
  logic               below_r, full_r;
  logic [NB-1:0]      num_r;
  logic [SEG_W-1:0]   seg_r;
  logic [F:0]         frac_r;
  logic [MW-1:0]      mix_r;
  logic [7:0]         rgb_r [3];
  logic [31:0]        hue_r, lf_r;
  logic [2:0]         sect_r;
  logic               out_valid_r;

  // fold
  logic signed [31:0] base_lo, base_hi, vin;
  assign vin = $signed(in_tdata);
  always_comb begin
    base_lo = low_r;
    base_hi = high_r;
    if (pass_start_r) begin
      base_lo = kind_r ? 32'sd0 : 32'sh7FFFFFFF;
      base_hi = kind_r ? 32'sd0 : 32'sh80000000;
    end
  end

  // scalar prep
  logic signed [32:0] d_s;
  logic [32:0]        hi_lo;
  logic [31:0]        span_c;
  logic [PW-1:0]      prod_c;
  assign d_s    = $signed({value_r[31], value_r}) - $signed({low_r[31], low_r});
  assign hi_lo  = 33'({high_r[31], high_r}) - 33'({low_r[31], low_r});
  assign span_c = (high_r > low_r) ? hi_lo[31:0] : 32'd1;
  assign prod_c = PW'(d_s[31:0]) * PW'(SEG_COUNT);

  // divider step
  logic [32:0] rem2;
  logic        ge;
  assign rem2 = {rem_r, num_r[NB-1]};
  assign ge   = rem2 >= {1'b0, span_r};

  // segment select
  logic [QW-1:0]    pos;
  logic [SEG_W-1:0] seg_c;
  always_comb begin
    pos = below_r ? '0 : (full_r ? FULL_POS : num_r[QW-1:0]);
    seg_c = pos[QW-1:F];
    if (seg_c >= SEG_W'(SEG_COUNT)) seg_c = SEG_W'(SEG_COUNT - 1);
  end

  // interpolation
  logic [2:0]              map_sel;
  logic [STOP_BITS:0]      sa, sb;
  logic signed [PMW-1:0]   diffm, mixf;
  logic [MW+7:0]           scaled;
  assign map_sel = (cmap_r < 3'(MAP_COUNT)) ? cmap_r : 3'd0;
  assign sa      = STOP_TABLE[map_sel][seg_r][cmd.ch];
  assign sb      = STOP_TABLE[map_sel][seg_r + SEG_W'(1)][cmd.ch];
  assign diffm   = PMW'($signed({1'b0, sb}) - $signed({1'b0, sa}))
                   * $signed(PMW'({1'b0, frac_r}));
  assign mixf    = $signed(PMW'({sa, {F{1'b0}}})) + diffm;
  assign scaled  = {mix_r, 8'd0} - (MW+8)'(mix_r);

  // label colour
  logic [34:0] h6;
  logic [45:0] q_c, t_c;
  logic [7:0]  qb, tb, lr, lg, lb;
  logic        lblack;
  assign h6     = {3'd0, hue_r} * 35'd6;
  assign q_c    = 46'd969 * (46'd1 << 34) - 46'd2907 * 46'(lf_r);
  assign t_c    = 46'd969 * (46'd1 << 32) + 46'd2907 * 46'(lf_r);
  assign qb     = q_c[43:36];
  assign tb     = t_c[43:36];
  assign lblack = value_r[31] || (value_r == 32'd0);
  always_comb begin
    case (sect_r)
      3'd0:    begin lr = 8'd242; lg = tb;     lb = 8'd63;  end
      3'd1:    begin lr = qb;     lg = 8'd242; lb = 8'd63;  end
      3'd2:    begin lr = 8'd63;  lg = 8'd242; lb = tb;     end
      3'd3:    begin lr = 8'd63;  lg = qb;     lb = 8'd242; end
      3'd4:    begin lr = tb;     lg = 8'd63;  lb = 8'd242; end
      default: begin lr = 8'd242; lg = 8'd63;  lb = qb;     end
    endcase
    if (lblack) begin
      lr = 8'd0; lg = 8'd0; lb = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmap_r       <= 3'd0;
      kind_r       <= 1'b0;
      low_r        <= 32'sh7FFFFFFF;
      high_r       <= 32'sh80000000;
      pass_start_r <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_COLORMAP: cmap_r <= cfg_data;
          REG_KIND:     kind_r <= cfg_data[0];
          default:      ;
        endcase
      end
      if (cmd.fold) begin
        low_r        <= (vin < base_lo) ? vin : base_lo;
        high_r       <= (vin > base_hi) ? vin : base_hi;
        pass_start_r <= in_tlast;
      end else if (cmd.capture) begin
        pass_start_r <= 1'b1;
      end
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      value_r <= in_tdata;
      mode_r  <= in_tuser;
      last_r  <= in_tlast;
    end
    if (cmd.prep) begin
      span_r  <= span_c;
      below_r <= d_s[32];
      full_r  <= !d_s[32] && (d_s[31:0] >= span_c);
      num_r   <= {prod_c, {F{1'b0}}};
      rem_r   <= 32'd0;
    end
    if (cmd.div_step) begin
      rem_r <= ge ? 32'(rem2 - {1'b0, span_r}) : rem2[31:0];
      num_r <= {num_r[NB-2:0], ge};
    end
    if (cmd.sel) begin
      seg_r  <= seg_c;
      frac_r <= (F+1)'(pos) - (F+1)'({seg_c, {F{1'b0}}});
    end
    if (cmd.mix) mix_r <= mixf[MW-1:0];
    if (cmd.byte_w) rgb_r[cmd.ch] <= scaled[F+23:F+16];
    if (cmd.lhue) hue_r <= value_r * GOLDEN_Q32;
    if (cmd.lsect) begin
      sect_r <= h6[34:32];
      lf_r   <= h6[31:0];
    end
    if (cmd.lrgb) begin
      rgb_r[0] <= lr;
      rgb_r[1] <= lg;
      rgb_r[2] <= lb;
    end
    if (cmd.out_load) begin
      if (mode_r) begin
        out_tdata <= {high_r, low_r, 8'd255, rgb_r[2], rgb_r[1], rgb_r[0]};
        out_tlast <= last_r;
      end else begin
        out_tdata <= {high_r, low_r, 32'd0};
        out_tlast <= 1'b1;
      end
    end
  end

  assign out_tvalid  = out_valid_r;
  assign st.kind     = kind_r;
  assign st.out_busy = out_valid_r && !out_tready;
endmodule
`default_nettype wire

>>> rtl/slcm_ctrl.sv
// Controller state machine sequencing fold, divide, interpolate and label steps
`timescale 1ns / 1ps
`default_nettype none
`include "scalar_label_colormap_rgba_unit_assert.svh"
module slcm_ctrl #(
  parameter int FRACTION_BITS = slcm_pkg::FRACTION_BITS_DEF
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_tvalid,
  output logic               in_tready,
  input  wire                in_tuser,
  input  wire                in_tlast,
  input  wire slcm_pkg::status_t st,
  output slcm_pkg::cmd_t     cmd
);
  import slcm_pkg::*;

  localparam int NB = 32 + SEG_W + FRACTION_BITS;
  localparam int CW = $clog2(NB);

  state_t      state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [1:0]  ch_r, ch_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ch_r    <= 2'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ch_r    <= ch_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ch_nxt    = ch_r;
    cmd       = '0;
    cmd.ch    = ch_r;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          if (!in_tuser) begin
            cmd.fold = 1'b1;
            if (in_tlast) state_nxt = S_DONE;
          end else begin
            state_nxt = st.kind ? S_LHUE : S_PREP;
          end
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CW'(1);
        if (cnt_r == CW'(NB - 1)) state_nxt = S_SEL;
      end
      S_SEL: begin
        cmd.sel   = 1'b1;
        ch_nxt    = 2'd0;
        state_nxt = S_MIX;
      end
      S_MIX: begin
        cmd.mix   = 1'b1;
        state_nxt = S_BYTE;
      end
      S_BYTE: begin
        cmd.byte_w = 1'b1;
        if (ch_r == 2'd2) begin
          state_nxt = S_DONE;
        end else begin
          ch_nxt    = ch_r + 2'd1;
          state_nxt = S_MIX;
        end
      end
      S_LHUE: begin
        cmd.lhue  = 1'b1;
        state_nxt = S_LSECT;
      end
      S_LSECT: begin
        cmd.lsect = 1'b1;
        state_nxt = S_LRGB;
      end
      S_LRGB: begin
        cmd.lrgb  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!st.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `SLCM_ASSERT_IMP(a_load_free, clk, rst_n, cmd.out_load, !st.out_busy)
  `SLCM_ASSERT_NXT(a_div_end, clk, rst_n, state_r == S_DIV && cnt_r == CW'(NB - 1),
                   state_r == S_SEL)
  `SLCM_ASSERT_NXT(a_colour_busy, clk, rst_n, in_tvalid && in_tready && in_tuser,
                   state_r != S_IDLE)
endmodule
`default_nettype wire

>>> rtl/scalar_label_colormap_rgba_unit.sv
// Top level of the scalar and label colormap unit
// Range item without last gives no result; range item with last gives its result
// from the done state; a label colour item runs hue, sector and RGB steps, a scalar
// colour item prep, the bit-serial restoring divider, select and per-channel mix/byte.
// One item is in work at a time; the next is accepted once the result is registered.
// Synchronous active-low reset: config to 0, fold registers to the signed extremes.
`timescale 1ns / 1ps
`default_nettype none
module scalar_label_colormap_rgba_unit #(
  parameter int FRACTION_BITS = slcm_pkg::FRACTION_BITS_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_tvalid,
  output logic                            in_tready,
  input  wire  [31:0]                     in_tdata,   // value
  input  wire                             in_tuser,   // mode
  input  wire                             in_tlast,
  output logic                            out_tvalid,
  input  wire                             out_tready,
  // red, green, blue, alpha, range_low, range_high
  output logic [95:0]                     out_tdata,
  output logic                            out_tlast,
  input  wire                             cfg_we,
  input  wire  [slcm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [slcm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import slcm_pkg::*;

  cmd_t    cmd;
  status_t st;

  slcm_ctrl #(.FRACTION_BITS(FRACTION_BITS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .st        (st),
    .cmd       (cmd)
  );

  slcm_dp #(.FRACTION_BITS(FRACTION_BITS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );
endmodule
`default_nettype wire

>>> test/colormap_checker.sv
// Checker: watches the item and result channels, predicts RGBA/range results and compares
`timescale 1ns / 1ps
`default_nettype none
module colormap_checker (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  input  wire        in_tready,
  input  wire [31:0] in_tdata,
  input  wire        in_tuser,
  input  wire        in_tlast,
  input  wire        out_tvalid,
  input  wire        out_tready,
  input  wire [95:0] out_tdata,
  input  wire        out_tlast,
  input  wire        cfg_we,
  input  wire [slcm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [slcm_pkg::CFG_DATA_W-1:0] cfg_data,
  output int         fail_count,
  output int         pending,
  output int         result_count
);
  import slcm_pkg::*;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [31:0] lo;
    logic [31:0] hi;
    logic        eop;
  } pixel_t;

  pixel_t      expected_pixels[$];
  logic [2:0]  map_sel;
  logic        label_kind;
  logic signed [31:0] fold_lo, fold_hi;
  logic        fold_fresh;

  assign pending = expected_pixels.size();

  function automatic logic [7:0] lerp_byte(int map, int seg, longint unsigned frac, int ch);
    longint unsigned a, b, mix;
    a = STOP_TABLE[map][seg][ch];
    b = STOP_TABLE[map][seg+1][ch];
    mix = a * ((64'd1 << FRACTION_BITS_DEF) - frac) + b * frac;
    mix = (mix * 255) >> (FRACTION_BITS_DEF + STOP_BITS);
    return (mix > 255) ? 8'd255 : mix[7:0];
  endfunction

  function automatic pixel_t shade_scalar(logic signed [31:0] v);
    pixel_t r;
    longint lo, hi, vv;
    longint unsigned span, d, pos, seg, frac, full;
    int map;
    lo = fold_lo; hi = fold_hi; vv = v;
    full = 64'(SEG_COUNT) << FRACTION_BITS_DEF;
    span = (hi > lo) ? longint'(hi - lo) : 1;
    map = (map_sel < MAP_COUNT) ? map_sel : 0;
    if (vv < lo) pos = 0;
    else begin
      d = vv - lo;
      pos = (d >= span) ? full : ((d * SEG_COUNT) << FRACTION_BITS_DEF) / span;
    end
    seg = pos >> FRACTION_BITS_DEF;
    if (seg >= SEG_COUNT) seg = SEG_COUNT - 1;
    frac = pos - (seg << FRACTION_BITS_DEF);
    r = '0;
    r.red   = lerp_byte(map, int'(seg), frac, 0);
    r.green = lerp_byte(map, int'(seg), frac, 1);
    r.blue  = lerp_byte(map, int'(seg), frac, 2);
    return r;
  endfunction

  function automatic pixel_t shade_label(logic signed [31:0] v);
    pixel_t r;
    logic [31:0] hue;
    logic [63:0] prod, h6, frac;
    logic [7:0]  vb, pb, qb, tb;
    r = '0;
    if (v <= 0) return r;
    prod = 64'(v) * 64'(GOLDEN_Q32);
    hue = prod[31:0];
    h6 = 64'(hue) * 6;
    frac = {32'd0, h6[31:0]};
    vb = 8'd242; pb = 8'd63;
    qb = 8'((64'd969 * (64'd1 << 34) - 64'd2907 * frac) >> 36);
    tb = 8'((64'd969 * (64'd1 << 32) + 64'd2907 * frac) >> 36);
    case (h6[34:32])
      3'd0: {r.red, r.green, r.blue} = {vb, tb, pb};
      3'd1: {r.red, r.green, r.blue} = {qb, vb, pb};
      3'd2: {r.red, r.green, r.blue} = {pb, vb, tb};
      3'd3: {r.red, r.green, r.blue} = {pb, qb, vb};
      3'd4: {r.red, r.green, r.blue} = {tb, pb, vb};
      default: {r.red, r.green, r.blue} = {vb, pb, qb};
    endcase
    return r;
  endfunction

  task automatic predict_item(logic mode, logic signed [31:0] v, logic lst);
    pixel_t r;
    if (!mode) begin
      if (fold_fresh) begin
        fold_lo = label_kind ? 32'sd0 : 32'sh7FFFFFFF;
        fold_hi = label_kind ? 32'sd0 : 32'sh80000000;
        fold_fresh = 1'b0;
      end
      if (v < fold_lo) fold_lo = v;
      if (v > fold_hi) fold_hi = v;
      if (lst) begin
        fold_fresh = 1'b1;
        r = '0;
        r.lo = fold_lo; r.hi = fold_hi; r.eop = 1'b1;
        expected_pixels.push_back(r);
      end
    end else begin
      fold_fresh = 1'b1;
      r = label_kind ? shade_label(v) : shade_scalar(v);
      r.alpha = 8'd255;
      r.lo = fold_lo; r.hi = fold_hi; r.eop = lst;
      expected_pixels.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    pixel_t want, got;
    if (!rst_n) begin
      map_sel <= '0; label_kind <= 1'b0;
      fold_lo = 32'sh7FFFFFFF; fold_hi = 32'sh80000000; fold_fresh = 1'b1;
      fail_count <= 0; result_count <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_COLORMAP) map_sel <= cfg_data;
        else if (cfg_index == REG_KIND) label_kind <= cfg_data[0];
      end
      if (out_tvalid && out_tready) begin
        result_count <= result_count + 1;
        got = {out_tdata[7:0], out_tdata[15:8], out_tdata[23:16], out_tdata[31:24],
               out_tdata[63:32], out_tdata[95:64], out_tlast};
        if (expected_pixels.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_pixels.pop_front();
          if (want !== got) begin
            if (fail_count < 10)
              $display("mismatch: exp rgba %0d %0d %0d %0d lo %0d hi %0d last %0d, got rgba %0d %0d %0d %0d lo %0d hi %0d last %0d",
                want.red, want.green, want.blue, want.alpha, $signed(want.lo),
                $signed(want.hi), want.eop, got.red, got.green, got.blue, got.alpha,
                $signed(got.lo), $signed(got.hi), got.eop);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_tvalid && in_tready) predict_item(in_tuser, in_tdata, in_tlast);
    end
  end
endmodule
`default_nettype wire

>>> test/testbench.sv
// Testbench top: drives frames and register settings into the colormap unit, gives the verdict
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import slcm_pkg::*;

  logic        clk, rst_n;
  logic        in_tvalid, in_tready, in_tuser, in_tlast;
  logic [31:0] in_tdata;
  logic        out_tvalid, out_tready, out_tlast;
  logic [95:0] out_tdata;
  logic        cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int fail_count, pending, result_count, cycle_count, items_sent;

  scalar_label_colormap_rgba_unit DUT (.*);

  colormap_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver stall per result
  initial begin
    int gap;
    out_tready = 0;
    forever begin
      @(negedge clk);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      out_tready = 0;
      repeat (gap) @(negedge clk);
      out_tready = 1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("timeout");
      $display("FAILED: results differ");
      $finish;
    end
  end

  // valid stays high into a back-to-back item; a gap or the caller drops it
  task automatic send_item(logic mode, logic [31:0] v, logic lst, bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1; in_tuser <= mode; in_tdata <= v; in_tlast <= lst;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    in_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (70) @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= d;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic [31:0] rand_value(logic [31:0] lo, logic [31:0] hi);
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'(-$urandom_range(0, 3));
      2: return $urandom_range(0, 40);
      3: return 32'h7FFFFFF0 + $urandom_range(0, 15);
      4: return 32'h80000000 + $urandom_range(0, 15);
      default: return lo + ($urandom() % ((hi - lo) == 0 ? 1 : (hi - lo + 1)));
    endcase
  endfunction

  task automatic send_frame(int len);
    logic [31:0] base, width, vals[$];
    bit burst;
    burst = ($urandom_range(0, 4) == 0);
    base = $urandom(); width = (32'd1 << $urandom_range(0, 31)) + $urandom_range(0, 9);
    vals = {};
    for (int k = 0; k < len; k++) vals.push_back(rand_value(base, base + width));
    foreach (vals[k]) send_item(0, vals[k], k == len - 1, burst);
    foreach (vals[k]) send_item(1, vals[k] + $urandom_range(0, 2) - 1, k == len - 1, burst);
  endtask

  initial begin
    int lens;
    in_tvalid = 0; in_tuser = 0; in_tdata = 0; in_tlast = 0;
    cfg_we = 0; cfg_index = REG_COLORMAP; cfg_data = 0;
    cycle_count = 0; items_sent = 0;
    rst_n = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: colour before any range pass, extremes, broken pass, labels
    send_item(1, 32'h00000005, 0, 0);
    send_item(0, 32'h80000000, 0, 0);
    send_item(0, 32'h7FFFFFFF, 0, 0);
    send_item(1, 32'h00000000, 0, 0);
    send_item(1, 32'h80000000, 0, 0);
    send_item(1, 32'h7FFFFFFF, 1, 0);
    send_item(0, 32'd10, 0, 0);
    send_item(0, 32'd10, 1, 0);
    send_item(1, 32'd10, 1, 0);
    write_reg(REG_COLORMAP, 3'd7);
    send_item(0, 32'd0, 0, 0);
    send_item(0, 32'd600, 1, 0);
    for (int k = 0; k <= 6; k++) send_item(1, 32'(k * 100), k == 6, 0);
    write_reg(REG_KIND, 3'd1);
    send_item(0, 32'hFFFFFFFF, 1, 0);
    send_item(1, 32'hFFFFFFFF, 0, 0);
    send_item(1, 32'd0, 0, 0);
    send_item(1, 32'd1, 0, 0);
    send_item(1, 32'h7FFFFFFF, 1, 0);

    for (int phase = 0; phase < 14; phase++) begin
      write_reg(REG_COLORMAP, (phase < 2) ? 3'(phase * 4) : 3'($urandom_range(0, 7)));
      write_reg(REG_KIND, 3'((phase % 3) == 2));
      while (items_sent < (phase + 1) * 100 + 20) begin
        lens = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 12);
        if ($urandom_range(0, 9) == 0)
          send_item(1'($urandom_range(0, 1)), $urandom(), 1'($urandom_range(0, 1)), 0);
        else send_frame(lens);
      end
    end
    in_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    $display("covered %0d items and %0d results over all maps, scalar and label kinds",
             items_sent, result_count);
    if (fail_count == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end
endmodule
`default_nettype wire

>>> scalar_label_colormap_rgba_unit.f
+incdir+rtl
rtl/slcm_pkg.sv
rtl/slcm_dp.sv
rtl/slcm_ctrl.sv
rtl/scalar_label_colormap_rgba_unit.sv
test/colormap_checker.sv
test/testbench.sv
